### design/spm_pkg.sv
// Shared widths, types and register codes for the star point similarity map.
`default_nettype none
package spm_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int MAP_W      = 16;
  localparam int LUM_W      = 16;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int L2_W    = 2 * COORD_BITS + 1;
  localparam int DOT_W   = 2 * COORD_BITS + 2;
  localparam int NUM_W   = L2_W + FRAC_BITS;
  // The ratio |AC|/|AB| stays below 2^(COORD_BITS+1), so the quotient has QB bits.
  localparam int QB      = COORD_BITS + FRAC_BITS + 2;
  localparam int KC_W    = QB + 1;
  localparam int REM_W   = L2_W + 1;
  localparam int MUL_W   = DIFF_W + KC_W;
  localparam int SUM_W   = MUL_W + 1;
  localparam int SH_W    = SUM_W - FRAC_BITS;
  localparam int LATENCY = QB + 7;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_A_X = 4'd0,
    REG_SRC_A_Y = 4'd1,
    REG_SRC_B_X = 4'd2,
    REG_SRC_B_Y = 4'd3,
    REG_DST_A_X = 4'd4,
    REG_DST_A_Y = 4'd5,
    REG_DST_B_X = 4'd6,
    REG_DST_B_Y = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] star_x;
    logic [COORD_BITS-1:0] star_y;
    logic [LUM_W-1:0]      star_luminance;
  } star_in_t;

  typedef struct packed {
    logic signed [MAP_W-1:0] mapped_x;
    logic signed [MAP_W-1:0] mapped_y;
    logic [LUM_W-1:0]        mapped_luminance;
    logic                    degenerate;
  } star_out_t;

  // Values that ride along with a request through the divider.
  typedef struct packed {
    logic signed [DIFF_W-1:0] tx;
    logic signed [DIFF_W-1:0] ty;
    logic [COORD_BITS-1:0]    tax;
    logic [COORD_BITS-1:0]    tay;
    logic [LUM_W-1:0]         lum;
    logic                     degen;
  } side_t;

endpackage
`default_nettype wire

### design/star_point_similarity_map.sv
// Top level of the star point similarity map pipeline.
// Usage:
// Eight configuration registers hold source stars A, B and target stars TA, TB.
// They are written through the cfg_ channel, which is always ready; index i
// selects register i and indices past the last register are dropped.
// Configuration should only change while no star is in flight.
// A star request is taken at every rising edge where start is high; busy is
// never raised, so one star can enter in every cycle.
// Each request yields exactly one result on out_item, marked by out_valid for
// one cycle. Throughput is one star per cycle.
// The latency is set by the restoring divider, which resolves one quotient
// bit per stage for the dot and cross ratios in parallel.
// The receiver cannot stall; results are shown for one cycle only.
// A synchronous active-low reset clears all valid bits and the configuration
// registers; anything in flight is dropped.
// A vertical source baseline or a star on A gives degenerate with zero
// coordinates; luminance always passes through.
`default_nettype none
module star_point_similarity_map (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire spm_pkg::star_in_t                 in_item,
  output logic                                   out_valid,
  output spm_pkg::star_out_t                     out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spm_pkg::COORD_BITS-1:0]    cfg_data
);

  localparam int CB     = spm_pkg::COORD_BITS;
  localparam int DIFF_W = spm_pkg::DIFF_W;
  localparam int PROD_W = spm_pkg::PROD_W;
  localparam int L2_W   = spm_pkg::L2_W;
  localparam int DOT_W  = spm_pkg::DOT_W;
  localparam int KC_W   = spm_pkg::KC_W;
  localparam int MUL_W  = spm_pkg::MUL_W;
  localparam int SUM_W  = spm_pkg::SUM_W;
  localparam int SH_W   = spm_pkg::SH_W;
  localparam int MAP_W  = spm_pkg::MAP_W;
  localparam int FRAC   = spm_pkg::FRAC_BITS;

  // The pipeline never stalls, so both channels are always open.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers.
  logic [CB-1:0] ax_r, ay_r, bx_r, by_r, tax_r, tay_r, tbx_r, tby_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r  <= '0;
      ay_r  <= '0;
      bx_r  <= '0;
      by_r  <= '0;
      tax_r <= '0;
      tay_r <= '0;
      tbx_r <= '0;
      tby_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spm_pkg::REG_SRC_A_X: ax_r  <= cfg_data;
        spm_pkg::REG_SRC_A_Y: ay_r  <= cfg_data;
        spm_pkg::REG_SRC_B_X: bx_r  <= cfg_data;
        spm_pkg::REG_SRC_B_Y: by_r  <= cfg_data;
        spm_pkg::REG_DST_A_X: tax_r <= cfg_data;
        spm_pkg::REG_DST_A_Y: tay_r <= cfg_data;
        spm_pkg::REG_DST_B_X: tbx_r <= cfg_data;
        spm_pkg::REG_DST_B_Y: tby_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: differences against A and the degenerate test.
  logic                     s1_v_r;
  logic signed [DIFF_W-1:0] s1_wx_r, s1_wy_r, s1_ux_r, s1_uy_r;
  spm_pkg::side_t           s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_wx_r         <= $signed({1'b0, bx_r}) - $signed({1'b0, ax_r});
    s1_wy_r         <= $signed({1'b0, by_r}) - $signed({1'b0, ay_r});
    s1_ux_r         <= $signed({1'b0, in_item.star_x}) - $signed({1'b0, ax_r});
    s1_uy_r         <= $signed({1'b0, in_item.star_y}) - $signed({1'b0, ay_r});
    s1_side_r.tx    <= $signed({1'b0, tbx_r}) - $signed({1'b0, tax_r});
    s1_side_r.ty    <= $signed({1'b0, tby_r}) - $signed({1'b0, tay_r});
    s1_side_r.tax   <= tax_r;
    s1_side_r.tay   <= tay_r;
    s1_side_r.lum   <= in_item.star_luminance;
    s1_side_r.degen <= (ax_r == bx_r) ||
                       ((in_item.star_x == ax_r) && (in_item.star_y == ay_r));
  end

  // Stage 2: the six small products.
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_xx_r, s2_yy_r, s2_xy_r, s2_yx_r, s2_ww_r, s2_hh_r;
  spm_pkg::side_t           s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_xx_r   <= PROD_W'(s1_wx_r) * PROD_W'(s1_ux_r);
    s2_yy_r   <= PROD_W'(s1_wy_r) * PROD_W'(s1_uy_r);
    s2_xy_r   <= PROD_W'(s1_wx_r) * PROD_W'(s1_uy_r);
    s2_yx_r   <= PROD_W'(s1_wy_r) * PROD_W'(s1_ux_r);
    s2_ww_r   <= PROD_W'(s1_wx_r) * PROD_W'(s1_wx_r);
    s2_hh_r   <= PROD_W'(s1_wy_r) * PROD_W'(s1_wy_r);
    s2_side_r <= s1_side_r;
  end

  // Stage 3: dot, cross and squared length, split into sign and magnitude.
  logic signed [DOT_W-1:0] dot, crs;
  logic [L2_W-1:0]         dot_mag, crs_mag;

  always_comb begin
    dot     = DOT_W'(s2_xx_r + s2_yy_r);
    crs     = DOT_W'(s2_xy_r - s2_yx_r);
    dot_mag = dot[DOT_W-1] ? L2_W'(-dot) : L2_W'(dot);
    crs_mag = crs[DOT_W-1] ? L2_W'(-crs) : L2_W'(crs);
  end

  logic                       s3_v_r;
  logic [spm_pkg::NUM_W-1:0]  s3_nd_r, s3_nc_r;
  logic                       s3_negd_r, s3_negc_r;
  logic [L2_W-1:0]            s3_l2_r;
  spm_pkg::side_t             s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_nd_r   <= {dot_mag, {FRAC{1'b0}}};
    s3_nc_r   <= {crs_mag, {FRAC{1'b0}}};
    s3_negd_r <= dot[DOT_W-1];
    s3_negc_r <= crs[DOT_W-1];
    s3_l2_r   <= L2_W'(s2_ww_r + s2_hh_r);
    s3_side_r <= s2_side_r;
  end

  // Divider: kc = floor(dot * 2^FRAC / l2), ks likewise for the cross product.
  logic                    dv_v;
  logic signed [KC_W-1:0]  dv_kc, dv_ks;
  spm_pkg::side_t          dv_side;

  spm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .num_dot   (s3_nd_r),
    .neg_dot   (s3_negd_r),
    .num_crs   (s3_nc_r),
    .neg_crs   (s3_negc_r),
    .den       (s3_l2_r),
    .in_side   (s3_side_r),
    .out_valid (dv_v),
    .kc        (dv_kc),
    .ks        (dv_ks),
    .out_side  (dv_side)
  );

  // Multiply stage: rotate and scale the target baseline.
  logic                    m_v_r;
  logic signed [MUL_W-1:0] m_p0_r, m_p1_r, m_p2_r, m_p3_r;
  spm_pkg::side_t          m_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    m_p0_r   <= MUL_W'(dv_side.tx) * MUL_W'(dv_kc);
    m_p1_r   <= MUL_W'(dv_side.ty) * MUL_W'(dv_ks);
    m_p2_r   <= MUL_W'(dv_side.ty) * MUL_W'(dv_kc);
    m_p3_r   <= MUL_W'(dv_side.tx) * MUL_W'(dv_ks);
    m_side_r <= dv_side;
  end

  // Sum stage.
  logic                    a_v_r;
  logic signed [SUM_W-1:0] a_sx_r, a_sy_r;
  spm_pkg::side_t          a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_sx_r   <= SUM_W'(m_p0_r) - SUM_W'(m_p1_r);
    a_sy_r   <= SUM_W'(m_p2_r) + SUM_W'(m_p3_r);
    a_side_r <= m_side_r;
  end

  // Output stage: floor by the arithmetic shift, offset by TA, saturate.
  logic signed [SH_W:0]    mx_wide, my_wide;
  logic signed [MAP_W-1:0] mx_sat, my_sat;
  logic signed [SH_W:0]    sat_hi, sat_lo;

  always_comb begin
    sat_hi  = (SH_W+1)'($signed({1'b0, {(MAP_W-1){1'b1}}}));
    sat_lo  = (SH_W+1)'($signed({1'b1, {(MAP_W-1){1'b0}}}));
    mx_wide = (SH_W+1)'(a_sx_r >>> FRAC) + $signed((SH_W+1)'(a_side_r.tax));
    my_wide = (SH_W+1)'(a_sy_r >>> FRAC) + $signed((SH_W+1)'(a_side_r.tay));
    if (mx_wide > sat_hi) begin
      mx_sat = MAP_W'(sat_hi);
    end else if (mx_wide < sat_lo) begin
      mx_sat = MAP_W'(sat_lo);
    end else begin
      mx_sat = MAP_W'(mx_wide);
    end
    if (my_wide > sat_hi) begin
      my_sat = MAP_W'(sat_hi);
    end else if (my_wide < sat_lo) begin
      my_sat = MAP_W'(sat_lo);
    end else begin
      my_sat = MAP_W'(my_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item.mapped_x         <= a_side_r.degen ? '0 : mx_sat;
    out_item.mapped_y         <= a_side_r.degen ? '0 : my_sat;
    out_item.mapped_luminance <= a_side_r.lum;
    out_item.degenerate       <= a_side_r.degen;
  end

endmodule
`default_nettype wire

### design/spm_div.sv
// Pipelined floor division of dot and cross products by the squared baseline length.
`default_nettype none
module spm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [spm_pkg::NUM_W-1:0]     num_dot,
  input  wire logic                          neg_dot,
  input  wire logic [spm_pkg::NUM_W-1:0]     num_crs,
  input  wire logic                          neg_crs,
  input  wire logic [spm_pkg::L2_W-1:0]      den,
  input  wire spm_pkg::side_t                in_side,
  output logic                               out_valid,
  output logic signed [spm_pkg::KC_W-1:0]    kc,
  output logic signed [spm_pkg::KC_W-1:0]    ks,
  output spm_pkg::side_t                     out_side
);

  localparam int QB   = spm_pkg::QB;
  localparam int L2_W = spm_pkg::L2_W;

  logic                      v_r      [0:QB];
  logic [L2_W-1:0]           rd_r     [0:QB];
  logic [L2_W-1:0]           rc_r     [0:QB];
  logic [QB-1:0]             qd_r     [0:QB];
  logic [QB-1:0]             qc_r     [0:QB];
  logic [QB-1:0]             nd_r     [0:QB];
  logic [QB-1:0]             nc_r     [0:QB];
  logic [L2_W-1:0]           den_r    [0:QB];
  logic                      negd_r   [0:QB];
  logic                      negc_r   [0:QB];
  spm_pkg::side_t            side_r   [0:QB];

  // Entry point; the numerator's top bits are already below the divisor.
  assign v_r[0]    = in_valid;
  assign rd_r[0]   = L2_W'(num_dot[spm_pkg::NUM_W-1:QB]);
  assign rc_r[0]   = L2_W'(num_crs[spm_pkg::NUM_W-1:QB]);
  assign qd_r[0]   = '0;
  assign qc_r[0]   = '0;
  assign nd_r[0]   = num_dot[QB-1:0];
  assign nc_r[0]   = num_crs[QB-1:0];
  assign den_r[0]  = den;
  assign negd_r[0] = neg_dot;
  assign negc_r[0] = neg_crs;
  assign side_r[0] = in_side;

  // One restoring step, one quotient bit per lane, in each stage.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [spm_pkg::REM_W-1:0] td, tc;
    logic                      gd, gc;

    always_comb begin
      td = {rd_r[k], nd_r[k][QB-1]};
      tc = {rc_r[k], nc_r[k][QB-1]};
      gd = (td >= {1'b0, den_r[k]});
      gc = (tc >= {1'b0, den_r[k]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rd_r[k+1]   <= gd ? L2_W'(td - {1'b0, den_r[k]}) : L2_W'(td);
      rc_r[k+1]   <= gc ? L2_W'(tc - {1'b0, den_r[k]}) : L2_W'(tc);
      qd_r[k+1]   <= {qd_r[k][QB-2:0], gd};
      qc_r[k+1]   <= {qc_r[k][QB-2:0], gc};
      nd_r[k+1]   <= {nd_r[k][QB-2:0], 1'b0};
      nc_r[k+1]   <= {nc_r[k][QB-2:0], 1'b0};
      den_r[k+1]  <= den_r[k];
      negd_r[k+1] <= negd_r[k];
      negc_r[k+1] <= negc_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  // Sign fix: a negative quotient with a remainder rounds down by one more.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (negd_r[QB]) begin
      kc <= (rd_r[QB] != '0) ? ~{1'b0, qd_r[QB]} : -{1'b0, qd_r[QB]};
    end else begin
      kc <= {1'b0, qd_r[QB]};
    end
    if (negc_r[QB]) begin
      ks <= (rc_r[QB] != '0) ? ~{1'b0, qc_r[QB]} : -{1'b0, qc_r[QB]};
    end else begin
      ks <= {1'b0, qc_r[QB]};
    end
    out_side <= side_r[QB];
  end

endmodule
`default_nettype wire

### design/spm_check.sv
// Port-level checks for the star point similarity map, bound to the top level.
`default_nettype none
module spm_check (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire spm_pkg::star_in_t    in_item,
  input wire logic                 out_valid,
  input wire spm_pkg::star_out_t   out_item
);

  localparam int LAT = spm_pkg::LATENCY;

  // Every result traces back to a request taken a fixed latency earlier.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // Luminance travels with its star through the whole pipeline.
  a_lum_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.mapped_luminance == $past(in_item.star_luminance, LAT))
    else $error("luminance does not match its request");

  // A degenerate result carries zero coordinates.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |->
      (out_item.mapped_x == '0 && out_item.mapped_y == '0))
    else $error("degenerate result with nonzero coordinates");

endmodule

bind star_point_similarity_map spm_check u_spm_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

### test/tb_star_point_similarity_map.sv
// Self-checking testbench for the star point similarity map: directed and random stars.
`default_nettype none
module tb_star_point_similarity_map;

  // Number of configuration registers. Indices at or above it must be dropped.
  localparam int NUM_CFG_REGS = 8;
  // Generous cycle limit for the whole run, far above the slowest correct run.
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [spm_pkg::COORD_BITS-1:0] COORD_MAX = '1;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  spm_pkg::star_in_t              in_item;
  logic                           out_valid;
  spm_pkg::star_out_t             out_item;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spm_pkg::COORD_BITS-1:0] cfg_data;

  // Our own copy of the eight frame registers, indexed by cfg_reg_t.
  logic [spm_pkg::COORD_BITS-1:0] frame_regs [NUM_CFG_REGS];
  // Mapped stars that are still owed by the block, oldest first.
  spm_pkg::star_out_t             pending_maps [$];
  int                             mismatch_count;
  int                             cycle_count;
  // Remaining requests in the current sender burst.
  int                             burst_left;

  star_point_similarity_map u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Floor division for a strictly positive divisor.
  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Predicts the mapped star from the current frame registers. The angle and
  // length ratio come exactly from integer dot and cross products against the
  // source baseline, then both ratios are floored to FRAC_BITS fraction bits.
  function automatic spm_pkg::star_out_t map_star(spm_pkg::star_in_t s);
    spm_pkg::star_out_t r;
    longint ax, ay, bx, by, tax, tay, tbx, tby, cx, cy, unit;
    longint wx, wy, ux, uy, tx, ty, l2, dot, crs, kc, ks, sx, sy;
    ax  = frame_regs[spm_pkg::REG_SRC_A_X];
    ay  = frame_regs[spm_pkg::REG_SRC_A_Y];
    bx  = frame_regs[spm_pkg::REG_SRC_B_X];
    by  = frame_regs[spm_pkg::REG_SRC_B_Y];
    tax = frame_regs[spm_pkg::REG_DST_A_X];
    tay = frame_regs[spm_pkg::REG_DST_A_Y];
    tbx = frame_regs[spm_pkg::REG_DST_B_X];
    tby = frame_regs[spm_pkg::REG_DST_B_Y];
    cx  = s.star_x;
    cy  = s.star_y;
    unit = longint'(1) << spm_pkg::FRAC_BITS;
    r.mapped_luminance = s.star_luminance;
    // A vertical source baseline (A equal to B included) or a star sitting on
    // A has no usable angle, so the block flags it and zeroes the position.
    if (ax == bx || (cx == ax && cy == ay)) begin
      r.mapped_x   = '0;
      r.mapped_y   = '0;
      r.degenerate = 1'b1;
      return r;
    end
    wx  = bx - ax;
    wy  = by - ay;
    ux  = cx - ax;
    uy  = cy - ay;
    tx  = tbx - tax;
    ty  = tby - tay;
    l2  = wx * wx + wy * wy;
    dot = wx * ux + wy * uy;
    crs = wx * uy - wy * ux;
    kc  = floor_quot(dot * unit, l2);
    ks  = floor_quot(crs * unit, l2);
    sx  = tx * kc - ty * ks;
    sy  = ty * kc + tx * ks;
    r.mapped_x   = spm_pkg::MAP_W'(clamp16(tax + floor_quot(sx, unit)));
    r.mapped_y   = spm_pkg::MAP_W'(clamp16(tay + floor_quot(sy, unit)));
    r.degenerate = 1'b0;
    return r;
  endfunction

  // Result checker. A result is on the ports for one cycle only and is taken
  // at the edge that ends it; it is compared against the oldest expectation.
  always @(posedge clk) begin
    spm_pkg::star_out_t want;
    if (rst_n && out_valid) begin
      if (pending_maps.size() == 0) begin
        $error("unexpected result: x=%0d y=%0d lum=%0h degenerate=%0b",
               out_item.mapped_x, out_item.mapped_y, out_item.mapped_luminance,
               out_item.degenerate);
        mismatch_count++;
      end else begin
        want = pending_maps.pop_front();
        if (out_item.mapped_x !== want.mapped_x) begin
          $error("mapped_x: expected %0d, actual %0d", want.mapped_x, out_item.mapped_x);
          mismatch_count++;
        end
        if (out_item.mapped_y !== want.mapped_y) begin
          $error("mapped_y: expected %0d, actual %0d", want.mapped_y, out_item.mapped_y);
          mismatch_count++;
        end
        if (out_item.mapped_luminance !== want.mapped_luminance) begin
          $error("mapped_luminance: expected %0h, actual %0h",
                 want.mapped_luminance, out_item.mapped_luminance);
          mismatch_count++;
        end
        if (out_item.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, actual %0b", want.degenerate, out_item.degenerate);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drops start for a random number of cycles, then opens a new burst.
  task automatic sender_gap();
    int gap;
    gap = $urandom_range(1, 6);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
    burst_left = $urandom_range(1, 12);
  endtask

  // Sends one star request and records what it must map to. Start stays high
  // across back-to-back requests inside a burst.
  task automatic send_star(logic [spm_pkg::COORD_BITS-1:0] x,
                           logic [spm_pkg::COORD_BITS-1:0] y,
                           logic [spm_pkg::LUM_W-1:0] lum);
    spm_pkg::star_in_t s;
    s.star_x         = x;
    s.star_y         = y;
    s.star_luminance = lum;
    start   <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_maps.push_back(map_star(s));
    burst_left--;
    if (burst_left <= 0) begin
      // Some bursts end with no gap at all, so long runs stay back to back.
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(4, 30);
      end else begin
        sender_gap();
      end
    end
  endtask

  // Waits until every owed result has come, then lets the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (spm_pkg::LATENCY + 2) @(posedge clk);
  endtask

  // Writes one register over the configuration channel. The caller makes
  // sure no star is in flight. cfg_valid is dropped again before the task returns.
  task automatic write_reg(logic [spm_pkg::CFG_IDX_W-1:0] idx,
                           logic [spm_pkg::COORD_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < NUM_CFG_REGS) begin
      frame_regs[idx] = val;
    end
    @(posedge clk);
  endtask

  task automatic set_frame(logic [spm_pkg::COORD_BITS-1:0] ax,
                           logic [spm_pkg::COORD_BITS-1:0] ay,
                           logic [spm_pkg::COORD_BITS-1:0] bx,
                           logic [spm_pkg::COORD_BITS-1:0] by,
                           logic [spm_pkg::COORD_BITS-1:0] tax,
                           logic [spm_pkg::COORD_BITS-1:0] tay,
                           logic [spm_pkg::COORD_BITS-1:0] tbx,
                           logic [spm_pkg::COORD_BITS-1:0] tby);
    drain();
    write_reg(spm_pkg::REG_SRC_A_X, ax);
    write_reg(spm_pkg::REG_SRC_A_Y, ay);
    write_reg(spm_pkg::REG_SRC_B_X, bx);
    write_reg(spm_pkg::REG_SRC_B_Y, by);
    write_reg(spm_pkg::REG_DST_A_X, tax);
    write_reg(spm_pkg::REG_DST_A_Y, tay);
    write_reg(spm_pkg::REG_DST_B_X, tbx);
    write_reg(spm_pkg::REG_DST_B_Y, tby);
  endtask

  // After reset every register is zero, so the baseline is vertical and every
  // star must come back degenerate with its luminance intact.
  task automatic test_reset_frame();
    send_star(12'd0, 12'd0, 16'h0000);
    send_star(COORD_MAX, COORD_MAX, 16'hFFFF);
    send_star(12'd5, 12'd7, 16'hA5A5);
  endtask

  // A horizontal baseline with a rotated target: the star on A, stars at the
  // coordinate extremes, stars on the vertical through A, stars on either
  // side of the baseline and one on its extension.
  task automatic test_directed_frame();
    set_frame(12'd100, 12'd100, 12'd300, 12'd100, 12'd2000, 12'd2000, 12'd2000, 12'd2400);
    send_star(12'd100, 12'd100, 16'h1234);
    send_star(12'd0, 12'd0, 16'h0001);
    send_star(COORD_MAX, COORD_MAX, 16'hFFFE);
    send_star(12'd0, COORD_MAX, 16'h8000);
    send_star(COORD_MAX, 12'd0, 16'h7FFF);
    send_star(12'd100, 12'd500, 16'h0F0F);
    send_star(12'd100, 12'd0, 16'hF0F0);
    send_star(12'd200, 12'd150, 16'h5555);
    send_star(12'd200, 12'd50, 16'hAAAA);
    send_star(12'd900, 12'd100, 16'h0000);
  endtask

  // Vertical baselines: A equal to B, and equal x with different y.
  task automatic test_vertical_baseline();
    set_frame(12'd700, 12'd700, 12'd700, 12'd700, 12'd10, 12'd20, 12'd30, 12'd40);
    send_star(12'd701, 12'd700, 16'hCAFE);
    send_star(12'd700, 12'd700, 16'hBEEF);
    set_frame(12'd700, 12'd0, 12'd700, COORD_MAX, 12'd10, 12'd20, 12'd30, 12'd40);
    send_star(12'd0, 12'd0, 16'h0042);
  endtask

  // A unit baseline with a full-length target pushes the mapped position far
  // past 16 bits in both directions, so both ends of saturation are hit.
  task automatic test_saturation();
    set_frame(12'd0, 12'd0, 12'd1, 12'd0, COORD_MAX, 12'd0, 12'd0, COORD_MAX);
    send_star(COORD_MAX, COORD_MAX, 16'h1111);
    send_star(COORD_MAX, 12'd0, 16'h2222);
    send_star(12'd0, COORD_MAX, 16'h3333);
    set_frame(COORD_MAX, COORD_MAX, 12'd4094, COORD_MAX, 12'd0, 12'd0, COORD_MAX, 12'd0);
    send_star(12'd0, 12'd0, 16'h4444);
  endtask

  // Writes to indices past the last register must change nothing.
  task automatic test_unused_index();
    logic [spm_pkg::CFG_IDX_W-1:0] idx;
    set_frame(12'd1000, 12'd1200, 12'd1500, 12'd900, 12'd300, 12'd3000, 12'd800, 12'd2500);
    for (int k = 0; k < (1 << spm_pkg::CFG_IDX_W) - NUM_CFG_REGS; k++) begin
      idx = spm_pkg::CFG_IDX_W'(NUM_CFG_REGS + k);
      write_reg(idx, spm_pkg::COORD_BITS'($urandom));
    end
    send_star(12'd1100, 12'd1300, 16'h0707);
    send_star(12'd4000, 12'd10, 16'h7070);
  endtask

  // Random frames, most of them well formed, each followed by a stream of
  // stars. Some stars land on A or close to it, the rest anywhere.
  task automatic test_random_frames();
    logic [spm_pkg::COORD_BITS-1:0] f [NUM_CFG_REGS];
    logic [spm_pkg::COORD_BITS-1:0] x, y;
    int                             pick, sent;
    sent = 0;
    while (sent < 500) begin
      for (int k = 0; k < NUM_CFG_REGS; k++) begin
        pick = $urandom_range(0, 9);
        f[k] = (pick == 0) ? '0 : (pick == 1) ? COORD_MAX :
               spm_pkg::COORD_BITS'($urandom);
      end
      // Short source baselines make large ratios and saturation likely.
      if ($urandom_range(0, 3) == 0) begin
        f[spm_pkg::REG_SRC_B_X] = f[spm_pkg::REG_SRC_A_X] +
                                  spm_pkg::COORD_BITS'($urandom_range(1, 3));
        f[spm_pkg::REG_SRC_B_Y] = f[spm_pkg::REG_SRC_A_Y] +
                                  spm_pkg::COORD_BITS'($urandom_range(0, 3));
      end
      if (f[spm_pkg::REG_SRC_B_X] == f[spm_pkg::REG_SRC_A_X] &&
          $urandom_range(0, 7) != 0) begin
        f[spm_pkg::REG_SRC_B_X] = f[spm_pkg::REG_SRC_A_X] + 1'b1;
      end
      set_frame(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
      for (int n = $urandom_range(20, 70); n > 0; n--) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          x = f[spm_pkg::REG_SRC_A_X];
          y = f[spm_pkg::REG_SRC_A_Y];
        end else if (pick < 3) begin
          x = f[spm_pkg::REG_SRC_A_X] + spm_pkg::COORD_BITS'($urandom_range(0, 16)) -
              spm_pkg::COORD_BITS'(8);
          y = f[spm_pkg::REG_SRC_A_Y] + spm_pkg::COORD_BITS'($urandom_range(0, 16)) -
              spm_pkg::COORD_BITS'(8);
        end else begin
          x = spm_pkg::COORD_BITS'($urandom);
          y = spm_pkg::COORD_BITS'($urandom);
        end
        send_star(x, y, spm_pkg::LUM_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 8;
    for (int k = 0; k < NUM_CFG_REGS; k++) begin
      frame_regs[k] = '0;
    end
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_frame();
    test_directed_frame();
    test_vertical_baseline();
    test_saturation();
    test_unused_index();
    test_random_frames();

    // Every star is in; wait for the last results, then a pipeline's worth more.
    drain();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
